>>> src/slcd_pkg.sv
// Shared types, constants and helper functions for the segment LCD value display.
// Holds the command codes, the segment location tables and the BCD conversion step.
// No dependencies; every other file of the block imports this package.
package slcd_pkg;

  // segment memory geometry
  localparam int RegCount  = 14;
  localparam int RegIdxW   = 4;
  localparam int ByteW     = 8;

  // item field widths
  localparam int CmdW      = 3;
  localparam int ValW      = 35;
  localparam int MagW      = ValW - 1;
  localparam int BatW      = 24;

  // stream bus widths
  localparam int InTdataW  = 64;
  localparam int OutTdataW = 16;

  // display layout
  localparam int NumDigits = 5;
  localparam int NumSegs   = 7;
  localparam int NumPoints = NumDigits - 1;
  localparam int PointW    = 3;
  localparam int LvlW      = 3;

  // double-dabble conversion, DdStep input bits per pipeline stage
  localparam int DdStep    = 4;
  localparam int DdStages  = (MagW + DdStep - 1) / DdStep;
  localparam int DdInW     = DdStages * DdStep;
  localparam int BcdDigits = 11;
  localparam int BcdW      = 4 * BcdDigits;
  localparam int DigIdxW   = 4;

  typedef enum logic [CmdW-1:0] {
    CmdClear   = 3'd0,
    CmdShow    = 3'd1,
    CmdIconT3  = 3'd2,
    CmdIconT2  = 3'd3,
    CmdIconOff = 3'd4
  } cmd_e;

  typedef logic [RegCount-1:0][ByteW-1:0] regs_t;
  typedef logic [RegCount-1:0]            regmask_t;

  // one item on its way through the conversion pipeline
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic              skip;
    logic [PointW-1:0] point;
    logic [LvlW-1:0]   bat_lvl;
    logic [DdInW-1:0]  bits;
    logic [BcdW-1:0]   bcd;
  } conv_t;

  // register writes handed from the shadow to the emitter
  typedef struct packed {
    regs_t    data;
    regmask_t mask;
    logic     desc;
  } burst_t;

  // magnitude ranges that pick the decimal point position
  localparam logic [MagW-1:0] Lim1e5  = 34'd100000;
  localparam logic [MagW-1:0] Lim1e6  = 34'd1000000;
  localparam logic [MagW-1:0] Lim1e7  = 34'd10000000;
  localparam logic [MagW-1:0] Lim1e8  = 34'd100000000;
  localparam logic [MagW-1:0] Lim1e10 = 34'd10000000000;

  // battery thresholds: full scale 3700000, then 55 %, 30 % and 10 % of it
  localparam logic [BatW-1:0] BatFull = 24'd3700000;
  localparam logic [BatW-1:0] Bat55   = 24'd2035000;
  localparam logic [BatW-1:0] Bat30   = 24'd1110000;
  localparam logic [BatW-1:0] Bat10   = 24'd370000;

  // segment locations a..g for each digit, most significant digit first
  localparam logic [RegIdxW-1:0] SegReg [NumDigits][NumSegs] = '{
    '{4'd1, 4'd5, 4'd8, 4'd12, 4'd8, 4'd1, 4'd5},
    '{4'd1, 4'd4, 4'd8, 4'd11, 4'd8, 4'd1, 4'd4},
    '{4'd1, 4'd4, 4'd8, 4'd11, 4'd8, 4'd1, 4'd4},
    '{4'd0, 4'd4, 4'd7, 4'd11, 4'd7, 4'd0, 4'd4},
    '{4'd0, 4'd4, 4'd7, 4'd11, 4'd7, 4'd0, 4'd4}
  };
  localparam logic [2:0] SegBit [NumDigits][NumSegs] = '{
    '{3'd4, 3'd0, 3'd4, 3'd0, 3'd5, 3'd5, 3'd1},
    '{3'd2, 3'd6, 3'd2, 3'd6, 3'd3, 3'd3, 3'd7},
    '{3'd0, 3'd4, 3'd0, 3'd4, 3'd1, 3'd1, 3'd5},
    '{3'd6, 3'd2, 3'd6, 3'd2, 3'd7, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd4, 3'd0, 3'd5, 3'd5, 3'd1}
  };

  // decimal points after digits one to four
  localparam logic [RegIdxW-1:0] RegPoint = 4'd11;
  localparam logic [2:0] PointBit [NumPoints] = '{3'd7, 3'd5, 3'd3, 3'd1};

  // battery gauge bars and frame
  localparam logic [RegIdxW-1:0] RegBar0  = 4'd0;
  localparam logic [RegIdxW-1:0] RegBar1  = 4'd3;
  localparam logic [RegIdxW-1:0] RegBar2  = 4'd7;
  localparam logic [RegIdxW-1:0] RegBar3  = 4'd10;
  localparam logic [2:0]         BitBar0  = 3'd0;
  localparam logic [2:0]         BitBar1  = 3'd4;
  localparam logic [2:0]         BitBar2  = 3'd0;
  localparam logic [2:0]         BitBar3  = 3'd4;
  localparam logic [2:0]         BitFrame = 3'd1;

  // icons
  localparam logic [RegIdxW-1:0] RegIconT2 = 4'd7;
  localparam logic [2:0]         BitIconT2 = 3'd3;
  localparam logic [RegIdxW-1:0] RegIconT3 = 4'd3;
  localparam logic [2:0]         BitIconT3 = 3'd7;

  // one double-dabble step: correct each digit, then shift in the next bit
  function automatic logic [BcdW-1:0] dd_shift(input logic [BcdW-1:0] bcd, input logic b);
    logic [BcdW-1:0] t;
    t = bcd;
    for (int d = 0; d < BcdDigits; d++) begin
      if (t[4*d +: 4] >= 4'd5) begin
        t[4*d +: 4] = t[4*d +: 4] + 4'd3;
      end
    end
    return {t[BcdW-2:0], b};
  endfunction

  // seven-segment patterns, bit 0 is segment a
  function automatic logic [NumSegs-1:0] glyph(input logic [3:0] digit);
    logic [NumSegs-1:0] g;
    case (digit)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = 7'h00;
    endcase
    return g;
  endfunction

endpackage

>>> src/slcd_front.sv
// Input register and binary-to-BCD conversion pipeline of the segment LCD display.
// Clamps the value, picks the point position and battery level, then converts
// the magnitude to decimal, DdStep bits per stage. Depends on slcd_pkg.
module slcd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         in_valid_i,
  input  logic [slcd_pkg::CmdW-1:0]    in_cmd_i,
  input  logic [slcd_pkg::ValW-1:0]    in_value_i,
  input  logic [slcd_pkg::BatW-1:0]    in_bat_i,
  output logic                         out_valid_o,
  output slcd_pkg::conv_t              out_item_o
);
  import slcd_pkg::*;

  logic                in_vld_q;
  logic [CmdW-1:0]     cmd_q;
  logic [ValW-1:0]     value_q;
  logic [BatW-1:0]     bat_q;
  logic [DdStages-1:0] st_vld_q;
  conv_t               st_q [DdStages];
  conv_t               st_d [DdStages];
  conv_t               seed;
  logic [MagW-1:0]     mag;

  // DdStep conversion steps on one item
  function automatic conv_t dd_run(input conv_t c);
    conv_t r;
    r = c;
    for (int k = 0; k < DdStep; k++) begin
      r.bcd  = dd_shift(r.bcd, r.bits[DdInW-1]);
      r.bits = {r.bits[DdInW-2:0], 1'b0};
    end
    return r;
  endfunction

  // clamp, range and battery level decode of the registered item
  always_comb begin
    mag = value_q[ValW-1] ? '0 : value_q[MagW-1:0];
    seed.cmd  = cmd_q;
    seed.skip = (mag >= Lim1e10);
    if (mag < Lim1e5) begin
      seed.point = PointW'(0);
    end else if (mag < Lim1e6) begin
      seed.point = PointW'(1);
    end else if (mag < Lim1e7) begin
      seed.point = PointW'(2);
    end else if (mag < Lim1e8) begin
      seed.point = PointW'(3);
    end else begin
      seed.point = PointW'(4);
    end
    if (bat_q >= BatFull) begin
      seed.bat_lvl = LvlW'(4);
    end else if (bat_q >= Bat55) begin
      seed.bat_lvl = LvlW'(3);
    end else if (bat_q > Bat30) begin
      seed.bat_lvl = LvlW'(2);
    end else if (bat_q > Bat10) begin
      seed.bat_lvl = LvlW'(1);
    end else begin
      seed.bat_lvl = LvlW'(0);
    end
    seed.bits = DdInW'(mag);
    seed.bcd  = '0;
  end

  // next contents of every conversion stage
  always_comb begin
    st_d[0] = dd_run(seed);
    for (int j = 1; j < DdStages; j++) begin
      st_d[j] = dd_run(st_q[j-1]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_vld_q <= '0;
    end else if (adv_i) begin
      in_vld_q <= in_valid_i;
      st_vld_q <= {st_vld_q[DdStages-2:0], in_vld_q};
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmd_q   <= in_cmd_i;
      value_q <= in_value_i;
      bat_q   <= in_bat_i;
      for (int j = 0; j < DdStages; j++) begin
        st_q[j] <= st_d[j];
      end
    end
  end

  assign out_valid_o = st_vld_q[DdStages-1];
  assign out_item_o  = st_q[DdStages-1];

endmodule

>>> src/slcd_shadow.sv
// Segment memory shadow of the segment LCD display.
// Applies one converted item to the shadow and builds the set of register writes.
// Depends on slcd_pkg.
module slcd_shadow (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  slcd_pkg::conv_t      item_i,
  output slcd_pkg::burst_t     burst_o
);
  import slcd_pkg::*;

  regs_t               shadow_q;
  regs_t               shadow_d;
  regs_t               sh;
  logic [DigIdxW-1:0]  didx;
  logic [3:0]          digit;
  logic [NumSegs-1:0]  g;
  logic [3:0]          bars;

  // new shadow contents and the writes they cause
  always_comb begin
    sh            = shadow_q;
    shadow_d      = shadow_q;
    burst_o.data  = '0;
    burst_o.mask  = '0;
    burst_o.desc  = 1'b0;
    didx          = '0;
    digit         = '0;
    g             = '0;
    bars          = '0;
    unique case (item_i.cmd) inside
      CmdClear: begin
        burst_o.mask = '1;
      end
      CmdShow: begin
        // digits and decimal points
        if (!item_i.skip) begin
          for (int i = 0; i < NumDigits; i++) begin
            didx  = DigIdxW'(item_i.point) + DigIdxW'(NumDigits - 1 - i);
            digit = item_i.bcd[4*didx +: 4];
            g     = glyph(digit);
            for (int s = 0; s < NumSegs; s++) begin
              sh[SegReg[i][s]][SegBit[i][s]] = g[s];
              burst_o.mask[SegReg[i][s]]     = 1'b1;
            end
          end
          for (int i = 0; i < NumPoints; i++) begin
            sh[RegPoint][PointBit[i]] = (item_i.point == PointW'(i));
          end
          burst_o.mask[RegPoint] = 1'b1;
        end
        // battery gauge, frame stays as it was when no bar is lit
        for (int b = 0; b < 4; b++) begin
          bars[b] = (item_i.bat_lvl > LvlW'(b));
        end
        sh[RegBar0][BitBar0] = bars[0];
        sh[RegBar1][BitBar1] = bars[1];
        sh[RegBar2][BitBar2] = bars[2];
        sh[RegBar3][BitBar3] = bars[3];
        if (bars[0]) begin
          sh[RegBar0][BitFrame] = 1'b1;
        end
        burst_o.mask[RegBar0] = 1'b1;
        burst_o.mask[RegBar1] = 1'b1;
        burst_o.mask[RegBar2] = 1'b1;
        burst_o.mask[RegBar3] = 1'b1;
        burst_o.data = sh;
        shadow_d     = sh;
      end
      CmdIconT3, CmdIconT2, CmdIconOff: begin
        sh[RegIconT2][BitIconT2]  = (item_i.cmd == CmdIconT2);
        sh[RegIconT3][BitIconT3]  = (item_i.cmd == CmdIconT3);
        burst_o.mask[RegIconT2]   = 1'b1;
        burst_o.mask[RegIconT3]   = 1'b1;
        burst_o.desc              = 1'b1;
        burst_o.data              = sh;
        shadow_d                  = sh;
      end
      default: begin
      end
    endcase
  end

  // shadow register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q <= '0;
    end else if (load_i) begin
      shadow_q <= shadow_d;
    end
  end

endmodule

>>> src/slcd_emit.sv
// Write serializer and output register of the segment LCD display.
// Holds one item's register writes and sends them one per cycle on the result bus while the receiver is ready.
// Depends on slcd_pkg.
module slcd_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  slcd_pkg::burst_t              burst_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [slcd_pkg::RegIdxW-1:0]  out_index_o,
  output logic [slcd_pkg::ByteW-1:0]    out_data_o,
  output logic                          out_last_o
);
  import slcd_pkg::*;

  regs_t               data_q;
  regmask_t            mask_q;
  logic                desc_q;
  regmask_t            rest;
  logic [RegIdxW-1:0]  pick;
  logic                found;
  logic                step;
  logic                vld_q;
  logic [RegIdxW-1:0]  index_q;
  logic [ByteW-1:0]    byte_q;
  logic                last_q;

  // next register to write: lowest pending, or highest for icon items
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = 0; i < RegCount; i++) begin
      if (mask_q[i] && (desc_q || !found)) begin
        pick  = RegIdxW'(i);
        found = 1'b1;
      end
    end
    rest       = mask_q;
    rest[pick] = 1'b0;
    step       = found && (!vld_q || out_ready_i);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (load_i) begin
        mask_q <= burst_i.mask;
      end else if (step) begin
        mask_q <= rest;
      end
      if (step) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= burst_i.data;
      desc_q <= burst_i.desc;
    end
    if (step) begin
      index_q <= pick;
      byte_q  <= data_q[pick];
      last_q  <= (rest == '0);
    end
  end

  assign free_o      = (mask_q == '0);
  assign out_valid_o = vld_q;
  assign out_index_o = index_q;
  assign out_data_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

>>> src/segment_lcd_value_display.sv
// Segment LCD value display, top level.
// Slave stream: one item per command; tuser carries the command, tdata the value
// in ten-thousandths and the battery reading. Master stream: one item per segment
// register write, tdata carries register index and byte, tlast marks the final
// write of a command.
// An accepted item passes the input register and the 9-stage BCD conversion
// pipeline, then loads the write buffer, whose output register puts its writes
// on the result bus. The slave side takes one item per cycle while the pipeline
// can move. Each item then holds the write buffer until its writes have left it:
// show value 10 writes (4 when the digits are skipped), clear 14, icon 2, unknown
// none. The single write port of the result bus sets the sustained rate.
// Reset empties the pipeline and the write buffer and clears the 14-byte shadow.
// When the receiver stalls, the output register holds its write, the buffer and
// then the pipeline fill, and tready drops once the last stage is occupied.
// Depends on slcd_pkg, slcd_front, slcd_shadow and slcd_emit.
module segment_lcd_value_display (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [34:0] value_e4, [58:35] battery_level, [63:59] zero
  input  logic [slcd_pkg::InTdataW-1:0]    s_axis_tdata,
  // [2:0] command
  input  logic [slcd_pkg::CmdW-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [3:0] reg_index, [11:4] reg_data, [15:12] zero
  output logic [slcd_pkg::OutTdataW-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast
);
  import slcd_pkg::*;

  logic               adv;
  logic               load;
  logic               front_valid;
  conv_t              front_item;
  burst_t             burst;
  logic               emit_free;
  logic [RegIdxW-1:0] out_index;
  logic [ByteW-1:0]   out_data;

  // pipeline moves when its last stage is empty or hands over to the buffer
  assign load          = front_valid && emit_free;
  assign adv           = !front_valid || load;
  assign s_axis_tready = adv;

  slcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_value_i  (s_axis_tdata[ValW-1:0]),
    .in_bat_i    (s_axis_tdata[ValW +: BatW]),
    .out_valid_o (front_valid),
    .out_item_o  (front_item)
  );

  slcd_shadow u_shadow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .item_i  (front_item),
    .burst_o (burst)
  );

  slcd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (emit_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_data_o  (out_data),
    .out_last_o  (m_axis_tlast)
  );

  // result bus packing
  assign m_axis_tdata = {{(OutTdataW - RegIdxW - ByteW){1'b0}}, out_data, out_index};

endmodule
